// File: sv/tqps_pkg.sv
package tqps_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic [ID_WIDTH-1:0] id_t;
  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [1:0] {
    OP_INS_COMMON = 2'd0,
    OP_INS_PREF   = 2'd1,
    OP_EXECUTE    = 2'd2,
    OP_FINISH     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // decoded request handed from front to back
  typedef struct packed {
    op_t op;
    id_t id;
  } cmd_t;

  // next read index, wraps at the queue depth
  function automatic ptr_t ptr_inc(ptr_t p);
    ptr_t r;
    if (p == ptr_t'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

  // tail slot (head + fill) mod depth, the sum stays below twice the depth
  function automatic ptr_t tail_idx(ptr_t h, cnt_t f);
    logic [CNT_W:0] s;
    s = {{(CNT_W + 1 - PTR_W){1'b0}}, h} + {1'b0, f};
    if (s >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

// File: sv/tqps_ram.sv
module tqps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/tqps_front.sv
module tqps_front import tqps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  id_t        proc_id,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_take
);

  // two-entry command queue
  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  op_t        op_dec;
  logic       push;

  always_comb begin
    unique case (action)
      2'd0:    op_dec = OP_INS_COMMON;
      2'd1:    op_dec = OP_INS_PREF;
      2'd2:    op_dec = OP_EXECUTE;
      default: op_dec = OP_FINISH;
    endcase
  end

  assign in_stall  = (count == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{op: op_dec, id: proc_id};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(cmd_take);
    end
  end

endmodule

// File: sv/tqps_back.sv
module tqps_back import tqps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_take,
  output logic       out_valid,
  input  logic       out_stall,
  output id_t        moved_id,
  output logic [1:0] status,
  output cnt_t       common_count,
  output cnt_t       pref_count
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t  state, state_next;
  ptr_t    common_head, common_head_next;
  cnt_t    common_fill, common_fill_next;
  ptr_t    pref_head, pref_head_next;
  cnt_t    pref_fill, pref_fill_next;
  logic    r_pop_pref;
  logic    r_push_common;
  status_t status_reg;

  logic    out_free;
  logic    c_full, p_full, c_empty, p_empty;
  logic    ins_c, ins_p, rd_pref, rd_common, push_after;
  status_t dec_status;
  logic    fin_idle, fin_read;
  logic    c_push, c_pop, p_push, p_pop;

  logic    c_we;
  id_t     c_wdata;
  id_t     c_rdata;
  id_t     p_rdata;
  id_t     rd_id;

  assign out_free = !out_valid || !out_stall;
  assign c_full   = (common_fill == cnt_t'(QUEUE_DEPTH));
  assign p_full   = (pref_fill == cnt_t'(QUEUE_DEPTH));
  assign c_empty  = (common_fill == '0);
  assign p_empty  = (pref_fill == '0);

  // decide the request against the current fills
  always_comb begin
    ins_c      = 1'b0;
    ins_p      = 1'b0;
    rd_pref    = 1'b0;
    rd_common  = 1'b0;
    push_after = 1'b0;
    dec_status = ST_OK;
    unique case (cmd.op)
      OP_INS_COMMON: begin
        if (c_full) dec_status = ST_FULL;
        else        ins_c = 1'b1;
      end
      OP_INS_PREF: begin
        if (p_full) dec_status = ST_FULL;
        else        ins_p = 1'b1;
      end
      OP_EXECUTE: begin
        if (!p_empty) begin
          if (c_full) begin
            dec_status = ST_FULL;
          end else begin
            rd_pref    = 1'b1;
            push_after = 1'b1;
          end
        end else if (!c_empty) begin
          rd_common  = 1'b1;
          push_after = 1'b1;
        end else begin
          dec_status = ST_EMPTY;
        end
      end
      default: begin
        if (!p_empty)      rd_pref    = 1'b1;
        else if (!c_empty) rd_common  = 1'b1;
        else               dec_status = ST_EMPTY;
      end
    endcase
  end

  assign cmd_take = (state == S_IDLE) && cmd_valid && out_free;
  assign fin_idle = cmd_take && !rd_pref && !rd_common;
  assign fin_read = (state == S_READ) && out_free;
  assign rd_id    = r_pop_pref ? p_rdata : c_rdata;

  always_comb begin
    c_push = 1'b0;
    c_pop  = 1'b0;
    p_push = 1'b0;
    p_pop  = 1'b0;
    if (fin_idle) begin
      c_push = ins_c;
      p_push = ins_p;
    end
    if (fin_read) begin
      c_push = r_push_common;
      c_pop  = !r_pop_pref;
      p_pop  = r_pop_pref;
    end
    common_fill_next = common_fill + cnt_t'(c_push) - cnt_t'(c_pop);
    pref_fill_next   = pref_fill + cnt_t'(p_push) - cnt_t'(p_pop);
    common_head_next = c_pop ? ptr_inc(common_head) : common_head;
    pref_head_next   = p_pop ? ptr_inc(pref_head) : pref_head;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd_take && (rd_pref || rd_common)) state_next = S_READ;
      S_READ: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // common tail write: insert from the command, or the id that was read
  assign c_we    = c_push;
  assign c_wdata = fin_read ? rd_id : cmd.id;

  tqps_ram #(.WIDTH(ID_WIDTH), .DEPTH(QUEUE_DEPTH)) u_common_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (tail_idx(common_head, common_fill)),
    .wdata (c_wdata),
    .re    (cmd_take && rd_common),
    .raddr (common_head),
    .rdata (c_rdata)
  );

  tqps_ram #(.WIDTH(ID_WIDTH), .DEPTH(QUEUE_DEPTH)) u_pref_ram (
    .clk   (clk),
    .we    (p_push),
    .waddr (tail_idx(pref_head, pref_fill)),
    .wdata (cmd.id),
    .re    (cmd_take && rd_pref),
    .raddr (pref_head),
    .rdata (p_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      common_head <= '0;
      common_fill <= '0;
      pref_head   <= '0;
      pref_fill   <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      common_head <= common_head_next;
      common_fill <= common_fill_next;
      pref_head   <= pref_head_next;
      pref_fill   <= pref_fill_next;
      if (fin_idle || fin_read) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      r_pop_pref    <= rd_pref;
      r_push_common <= push_after;
    end
    if (fin_idle) begin
      moved_id   <= (ins_c || ins_p) ? cmd.id : '0;
      status_reg <= dec_status;
    end
    if (fin_read) begin
      moved_id   <= rd_id;
      status_reg <= ST_OK;
    end
    if (fin_idle || fin_read) begin
      common_count <= common_fill_next;
      pref_count   <= pref_fill_next;
    end
  end

  assign status = status_reg;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (common_fill <= cnt_t'(QUEUE_DEPTH)) && (pref_fill <= cnt_t'(QUEUE_DEPTH)))
    else $error("queue fill beyond depth");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> (state == S_IDLE))
    else $error("command taken while a read is pending");

  a_read_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ && out_free) |=> (state == S_IDLE && out_valid))
    else $error("read completion did not post a result");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_reg != ST_OK) |-> (moved_id == '0))
    else $error("flagged result carries an id");

endmodule

// File: sv/two_queue_promotion_scheduler_unit.sv
// channel  | handshake                 | payload
// ---------+---------------------------+-------------------------------------------------
// request  | in_valid / in_stall       | action, proc_id
// result   | out_valid / out_stall     | moved_id, status, common_count, pref_count
//
// inserts and flagged requests finish in the back end's idle state; pops (execute, finish) go through a read state:
// the queue memory head is read, then the result is posted and an execute also writes the common tail
// the two-entry command queue registers each request before the back end sees it
// rst is synchronous and clears heads, fills and handshake state; queue memories are not cleared
// out_stall holds the result register and the back end; the front keeps taking items until
// its queue is full, then raises in_stall
module two_queue_promotion_scheduler_unit import tqps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  id_t        proc_id,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output id_t        moved_id,
  output logic [1:0] status,
  output cnt_t       common_count,
  output cnt_t       pref_count
);

  // decoded command between front and back
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  // front: decode action and buffer requests
  tqps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .proc_id   (proc_id),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // back: queue memories, heads, fills and the result register
  tqps_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .moved_id     (moved_id),
    .status       (status),
    .common_count (common_count),
    .pref_count   (pref_count)
  );

endmodule

// File: bench/two_queue_promotion_scheduler_unit_test.sv
`timescale 1ns / 100ps

module two_queue_promotion_scheduler_unit_test;
  import tqps_pkg::*;

  // one result as the scheduler should report it
  typedef struct packed {
    id_t     id;
    status_t st;
    cnt_t    cc;
    cnt_t    pc;
  } sched_result_t;

  // mirrors both queues and holds the results still owed by the block
  class sched_tracker;
    id_t           common_ids[$];
    id_t           pref_ids[$];
    sched_result_t due_results[$];
    int            errors;
    int            checked;
    int            taken;
    int            n_ok;
    int            n_empty;
    int            n_full;

    function void take_request(op_t op, id_t id);
      sched_result_t r;
      r.id = '0;
      r.st = ST_OK;
      case (op)
        OP_INS_COMMON: begin
          if (common_ids.size() >= QUEUE_DEPTH) begin
            r.st = ST_FULL;
          end else begin
            common_ids.push_back(id);
            r.id = id;
          end
        end
        OP_INS_PREF: begin
          if (pref_ids.size() >= QUEUE_DEPTH) begin
            r.st = ST_FULL;
          end else begin
            pref_ids.push_back(id);
            r.id = id;
          end
        end
        OP_EXECUTE: begin
          if (pref_ids.size() != 0) begin
            if (common_ids.size() >= QUEUE_DEPTH) begin
              r.st = ST_FULL;
            end else begin
              r.id = pref_ids.pop_front();
              common_ids.push_back(r.id);
            end
          end else if (common_ids.size() != 0) begin
            // rotate the common head to its tail
            r.id = common_ids.pop_front();
            common_ids.push_back(r.id);
          end else begin
            r.st = ST_EMPTY;
          end
        end
        default: begin
          if (pref_ids.size() != 0) begin
            r.id = pref_ids.pop_front();
          end else if (common_ids.size() != 0) begin
            r.id = common_ids.pop_front();
          end else begin
            r.st = ST_EMPTY;
          end
        end
      endcase
      r.cc = cnt_t'(common_ids.size());
      r.pc = cnt_t'(pref_ids.size());
      case (r.st)
        ST_OK:    n_ok++;
        ST_EMPTY: n_empty++;
        default:  n_full++;
      endcase
      taken++;
      due_results.push_back(r);
    endfunction

    function void check_result(id_t got_id, logic [1:0] got_st, cnt_t got_cc, cnt_t got_pc);
      sched_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: id %h status %0d counts %0d/%0d",
                   got_id, got_st, got_cc, got_pc);
        end
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (got_id !== want.id || got_st !== want.st || got_cc !== want.cc ||
          got_pc !== want.pc) begin
        errors++;
        if (errors <= 10) begin
          $display("result %0d: expected id %h status %0d common %0d pref %0d",
                   checked, want.id, want.st, want.cc, want.pc);
          $display("result %0d: got      id %h status %0d common %0d pref %0d",
                   checked, got_id, got_st, got_cc, got_pc);
        end
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] action;
  id_t        proc_id;
  logic       out_valid;
  logic       out_stall;
  id_t        moved_id;
  logic [1:0] status;
  cnt_t       common_count;
  cnt_t       pref_count;

  sched_tracker trk = new();

  // idling odds in percent, set per phase
  int send_idle_pct;
  int recv_stall_pct;
  // long receiver hold-off, requested by the main sequence, counted by the receiver
  int   hold_request;
  int   hold_left;
  logic hold_taken;

  two_queue_promotion_scheduler_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .proc_id      (proc_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .moved_id     (moved_id),
    .status       (status),
    .common_count (common_count),
    .pref_count   (pref_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watch both channels; a request is noted before any result of the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        trk.take_request(op_t'(action), proc_id);
      end
      if (out_valid && !out_stall) begin
        trk.check_result(moved_id, status, common_count, pref_count);
      end
    end
  end

  // result side stall
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_taken = 1'b0;
    end else begin
      if (hold_request > 0 && !hold_taken) begin
        hold_left = hold_request;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // offer one request and hold it until taken
  task automatic send_request(op_t op, id_t id);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= op;
    proc_id  <= id;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait for every owed result
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (trk.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic op_t pick_op(int w_ic, int w_ip, int w_ex);
    int r;
    r = $urandom_range(99);
    if (r < w_ic) return OP_INS_COMMON;
    if (r < w_ic + w_ip) return OP_INS_PREF;
    if (r < w_ic + w_ip + w_ex) return OP_EXECUTE;
    return OP_FINISH;
  endfunction

  function automatic id_t pick_id();
    int r;
    r = $urandom_range(7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return id_t'($urandom);
  endfunction

  initial begin
    #2000000;
    $display("two_queue_promotion_scheduler_unit: mismatch");
    $finish;
  end

  initial begin
    int p;
    int k;
    int w_ic;
    int w_ip;
    int w_ex;

    rst            = 1'b1;
    in_valid       = 1'b0;
    action         = OP_INS_COMMON;
    proc_id        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty requests, extreme ids, promote, rotate, both finish paths
    send_request(OP_FINISH, 16'h1234);
    send_request(OP_EXECUTE, 16'hffff);
    send_request(OP_INS_COMMON, 16'h0000);
    send_request(OP_INS_COMMON, 16'hffff);
    send_request(OP_INS_PREF, 16'ha5a5);
    send_request(OP_INS_PREF, 16'h5a5a);
    send_request(OP_EXECUTE, 16'h0000);
    send_request(OP_EXECUTE, 16'hffff);
    send_request(OP_EXECUTE, 16'h0000);   // preferred empty: rotate
    send_request(OP_EXECUTE, 16'h0000);
    send_request(OP_INS_PREF, 16'h8000);
    send_request(OP_FINISH, 16'hffff);    // drops the preferred head
    send_request(OP_FINISH, 16'h0000);    // then the common ones
    send_request(OP_FINISH, 16'h0000);
    send_request(OP_FINISH, 16'h0000);
    send_request(OP_FINISH, 16'h0000);
    send_request(OP_FINISH, 16'h0000);    // empty again
    send_request(OP_INS_COMMON, 16'h0001);
    send_request(OP_EXECUTE, 16'h0000);   // rotate with a single entry
    send_request(OP_FINISH, 16'h0000);
    wait_drained();

    // random phases: the action mix drives fill levels up to full and back down
    for (p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      case (p % 5)
        0: begin w_ic = 25; w_ip = 25; w_ex = 25; end
        1: begin w_ic = 40; w_ip = 40; w_ex = 10; end
        2: begin w_ic = 10; w_ip = 10; w_ex = 30; end
        3: begin w_ic = 50; w_ip = 25; w_ex = 15; end
        default: begin w_ic = 45; w_ip = 0; w_ex = 45; end
      endcase
      // hold the result side off for a long while so the input backs up
      if (p == 1) begin
        hold_request = 300;
      end
      for (k = 0; k < 80; k++) begin
        send_request(pick_op(w_ic, w_ip, w_ex), pick_id());
      end
      if (p == 3 || p == 6) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (30) @(posedge clk);

    $display("covered %0d requests, %0d results checked: ok %0d, empty %0d, full %0d",
             trk.taken, trk.checked, trk.n_ok, trk.n_empty, trk.n_full);
    $display("mismatches %0d, results still owed %0d", trk.errors, trk.pending());
    if (trk.errors == 0 && trk.pending() == 0) begin
      $display("two_queue_promotion_scheduler_unit: match");
    end else begin
      $display("two_queue_promotion_scheduler_unit: mismatch");
    end
    $finish;
  end

endmodule
